@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion on clk_i, held off while rst_ni is low
`define ASSERT_P(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// condition that must never be seen
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_P(lbl, !(cond))

`endif

@@ src/cse_pkg.sv @@
package cse_pkg;

  localparam int DATA_W     = 32;
  localparam int EST_W      = 31;
  localparam int COEF_IDX_W = 4;
  localparam int ORDER_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int PC_W       = 4;
  localparam int PROG_LEN   = 12;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  localparam logic [PC_W-1:0] PC_DIV  = 4'd3;
  localparam logic [PC_W-1:0] PC_LOOP = 4'd5;
  localparam logic [PC_W-1:0] PC_TAIL = 4'd8;
  localparam logic [PC_W-1:0] PC_ZERO = 4'd11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER = 2'd0,
    CFG_LOW   = 2'd1,
    CFG_HIGH  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_INIT, OP_LOADV, OP_LOADU, OP_DIVSTEP, OP_SETT,
    OP_MUL, OP_ROUND, OP_REC, OP_FINAL, OP_ZERO
  } op_e;

  typedef enum logic [1:0] {RA_LAST, RA_PREV, RA_PTR} rd_sel_e;

  typedef enum logic [2:0] {J_NEXT, J_DERR, J_DIV, J_SHORT, J_LOOP, J_DONE} jmp_e;

  typedef struct packed {
    op_e             op;
    rd_sel_e         rd_sel;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_e     op;
    rd_sel_e rd_sel;
  } ctrl_t;

  typedef struct packed {
    logic derr;
    logic short_ord;
    logic div_last;
    logic ptr_last;
  } stat_t;

  typedef struct packed {
    logic [ORDER_W-1:0]       order;
    logic signed [DATA_W-1:0] low;
    logic signed [DATA_W-1:0] high;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] v;
    logic                     ov;
  } sat_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, rd_sel: RA_LAST, jmp: J_DONE, target: '0};
    case (pc)
      4'd0:  w = '{op: OP_INIT,    rd_sel: RA_LAST, jmp: J_NEXT,  target: '0};
      4'd1:  w = '{op: OP_LOADV,   rd_sel: RA_PREV, jmp: J_DERR,  target: PC_ZERO};
      4'd2:  w = '{op: OP_LOADU,   rd_sel: RA_LAST, jmp: J_NEXT,  target: '0};
      4'd3:  w = '{op: OP_DIVSTEP, rd_sel: RA_LAST, jmp: J_DIV,   target: PC_DIV};
      4'd4:  w = '{op: OP_SETT,    rd_sel: RA_LAST, jmp: J_SHORT, target: PC_TAIL};
      4'd5:  w = '{op: OP_MUL,     rd_sel: RA_PTR,  jmp: J_NEXT,  target: '0};
      4'd6:  w = '{op: OP_ROUND,   rd_sel: RA_PTR,  jmp: J_NEXT,  target: '0};
      4'd7:  w = '{op: OP_REC,     rd_sel: RA_PTR,  jmp: J_LOOP,  target: PC_LOOP};
      4'd8:  w = '{op: OP_MUL,     rd_sel: RA_LAST, jmp: J_NEXT,  target: '0};
      4'd9:  w = '{op: OP_ROUND,   rd_sel: RA_LAST, jmp: J_NEXT,  target: '0};
      4'd10: w = '{op: OP_FINAL,   rd_sel: RA_LAST, jmp: J_DONE,  target: '0};
      4'd11: w = '{op: OP_ZERO,    rd_sel: RA_LAST, jmp: J_DONE,  target: '0};
      default: w = '{op: OP_NOP, rd_sel: RA_LAST, jmp: J_DONE, target: '0};
    endcase
    return w;
  endfunction

endpackage

@@ src/cse_coef_mem.sv @@
module cse_coef_mem #(
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic signed [cse_pkg::DATA_W-1:0] wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic signed [cse_pkg::DATA_W-1:0] rdata_o
);
  import cse_pkg::*;

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/cse_ucode_seq.sv @@
`include "assert_macros.svh"

module cse_ucode_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            launch_i,
  input  cse_pkg::stat_t  stat_i,
  output cse_pkg::ctrl_t  ctrl_o,
  output logic            busy_o
);
  import cse_pkg::*;

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          word;
  logic            take;

  assign word = ucode(pc_q);

  always_comb begin
    case (word.jmp)
      J_NEXT:  take = 1'b0;
      J_DERR:  take = stat_i.derr;
      J_DIV:   take = !stat_i.div_last;
      J_SHORT: take = stat_i.short_ord;
      J_LOOP:  take = !stat_i.ptr_last;
      J_DONE:  take = 1'b0;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (busy_q) begin
      if (word.jmp == J_DONE) begin
        busy_d = 1'b0;
      end else if (take) begin
        pc_d = word.target;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end else if (launch_i) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  always_comb begin
    ctrl_o.op     = busy_q ? word.op : OP_NOP;
    ctrl_o.rd_sel = word.rd_sel;
  end

  assign busy_o = busy_q;

  `ASSERT_P(a_pc_in_prog, busy_q |-> pc_q < PC_W'(PROG_LEN))
  `ASSERT_P(a_done_frees, busy_q && word.jmp == J_DONE |=> !busy_q)
  `ASSERT_NEVER(a_launch_busy, launch_i && busy_q)

endmodule

@@ src/cse_datapath.sv @@
`include "assert_macros.svh"

module cse_datapath #(
  parameter int MAX_ORDER = 16,
  parameter int FRAC_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              launch_i,
  input  logic signed [cse_pkg::DATA_W-1:0] x_value_i,
  input  cse_pkg::ctrl_t                    ctrl_i,
  input  cse_pkg::cfg_t                     cfg_i,
  input  logic signed [cse_pkg::DATA_W-1:0] rd_data_i,
  output logic [$clog2(MAX_ORDER)-1:0]      rd_addr_o,
  output cse_pkg::stat_t                    stat_o,
  output logic                              done_o,
  output logic signed [cse_pkg::DATA_W-1:0] series_value_o,
  output logic [cse_pkg::EST_W-1:0]         error_estimate_o,
  output logic                              overflow_o,
  output logic                              domain_error_o
);
  import cse_pkg::*;

  localparam int AW = $clog2(MAX_ORDER);
  localparam int NW = $clog2(MAX_ORDER + 1);
  localparam int MW = 64 - FRAC_BITS;
  localparam int SW = 66;
  localparam logic signed [63:0] HALF_POS = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] HALF_NEG = HALF_POS - 64'sd1;
  localparam logic signed [SW-1:0] MAX_V = 66'sd2147483647;
  localparam logic signed [SW-1:0] MIN_V = -66'sd2147483648;
  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;

  function automatic sat_t sat32(input logic signed [SW-1:0] a);
    sat_t s;
    if (a > MAX_V) begin
      s.v  = MAX_V[DATA_W-1:0];
      s.ov = 1'b1;
    end else if (a < MIN_V) begin
      s.v  = MIN_V[DATA_W-1:0];
      s.ov = 1'b1;
    end else begin
      s.v  = a[DATA_W-1:0];
      s.ov = 1'b0;
    end
    return s;
  endfunction

  logic [NW-1:0] n;
  logic signed [DATA_W-1:0] x_q;
  logic signed [DATA_W-1:0] u_q, v_q, t_q;
  logic signed [63:0] prod_q;
  logic signed [MW-1:0] m_q;
  logic ov_q;
  logic [AW-1:0] ptr_q;

  logic [31:0] r_q, dlo_q, q_q, ud_q;
  logic [4:0]  cnt_q;
  logic        neg_q, dsat_q;

  logic done_q, ovf_q, derr_q;
  logic signed [DATA_W-1:0] val_q;
  logic [EST_W-1:0] est_q;

  // divider setup and other combinational datapath terms
  logic signed [33:0] num;
  logic signed [32:0] den;
  logic [33:0] un;
  logic [31:0] ud;
  logic [63:0] dvd, lim;
  logic [32:0] rs;
  logic        ge;
  logic [32:0] qm;
  logic signed [SW-1:0] qs;
  logic signed [63:0] rsum;
  logic signed [DATA_W-1:0] cneg;
  logic [EST_W-1:0] est_d;
  sat_t s_t, s_u, s_v, s_f;

  always_comb begin
    if (cfg_i.order == '0) begin
      n = NW'(1);
    end else if (32'(cfg_i.order) > MAX_ORDER) begin
      n = NW'(MAX_ORDER);
    end else begin
      n = NW'(cfg_i.order);
    end
  end

  always_comb begin
    case (ctrl_i.rd_sel)
      RA_LAST: rd_addr_o = AW'(n - NW'(1));
      RA_PREV: rd_addr_o = (n >= NW'(2)) ? AW'(n - NW'(2)) : '0;
      RA_PTR:  rd_addr_o = ptr_q;
      default: rd_addr_o = '0;
    endcase
  end

  always_comb begin
    stat_o.derr      = cfg_i.high == cfg_i.low;
    stat_o.short_ord = n < NW'(3);
    stat_o.div_last  = cnt_q == '0;
    stat_o.ptr_last  = ptr_q == '0;
  end

  always_comb begin
    num  = 34'(x_q) + 34'(x_q) - 34'(cfg_i.low) - 34'(cfg_i.high);
    den  = 33'(cfg_i.high) - 33'(cfg_i.low);
    un   = num[33] ? 34'(-num) : 34'(num);
    ud   = den[32] ? 32'(-den) : 32'(den);
    dvd  = 64'(un) << FRAC_BITS;
    lim  = 64'(ud) << (32 - FRAC_BITS);
    rs   = {r_q, dlo_q[31]};
    ge   = rs >= {1'b0, ud_q};
    qm   = dsat_q ? 33'h1_0000_0000 : {1'b0, q_q};
    qs   = neg_q ? -$signed(SW'(qm)) : $signed(SW'(qm));
    s_t  = sat32(qs);
    rsum = prod_q + (prod_q[63] ? HALF_NEG : HALF_POS);
    s_u  = sat32(SW'(rd_data_i) - SW'(v_q));
    s_v  = sat32(SW'(u_q) + SW'(m_q) + SW'(m_q));
    s_f  = sat32(SW'(u_q) + SW'(m_q));
    cneg = -rd_data_i;
    if (rd_data_i == MOST_NEG) begin
      est_d = '1;
    end else begin
      est_d = rd_data_i[DATA_W-1] ? cneg[EST_W-1:0] : rd_data_i[EST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch_i) begin
      x_q <= x_value_i;
    end
    case (ctrl_i.op)
      OP_INIT: begin
        r_q    <= dvd[63:32];
        dlo_q  <= dvd[31:0];
        ud_q   <= ud;
        neg_q  <= num[33] ^ den[32];
        dsat_q <= 64'(un) >= lim;
      end
      OP_LOADV: begin
        est_q <= est_d;
        v_q   <= (n >= NW'(2)) ? rd_data_i : '0;
      end
      OP_LOADU: u_q <= rd_data_i;
      OP_DIVSTEP: begin
        r_q   <= ge ? 32'(rs - {1'b0, ud_q}) : rs[31:0];
        dlo_q <= {dlo_q[30:0], 1'b0};
        q_q   <= {q_q[30:0], ge};
      end
      OP_SETT:  t_q <= s_t.v;
      OP_MUL:   prod_q <= v_q * t_q;
      OP_ROUND: m_q <= rsum[63:FRAC_BITS];
      OP_REC: begin
        u_q <= s_u.v;
        v_q <= s_v.v;
      end
      OP_FINAL: val_q <= s_f.v;
      OP_ZERO:  val_q <= '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ptr_q  <= '0;
      ov_q   <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      derr_q <= 1'b0;
    end else begin
      done_q <= (ctrl_i.op == OP_FINAL) || (ctrl_i.op == OP_ZERO);
      case (ctrl_i.op)
        OP_INIT: begin
          ov_q  <= 1'b0;
          cnt_q <= '1;
          ptr_q <= AW'(n - NW'(3));
        end
        OP_DIVSTEP: cnt_q <= cnt_q - 1'b1;
        OP_SETT:    ov_q <= ov_q | s_t.ov;
        OP_REC: begin
          ov_q  <= ov_q | s_u.ov | s_v.ov;
          ptr_q <= ptr_q - 1'b1;
        end
        OP_FINAL: begin
          ovf_q  <= ov_q | s_f.ov;
          derr_q <= 1'b0;
        end
        OP_ZERO: begin
          ovf_q  <= 1'b0;
          derr_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign done_o           = done_q;
  assign series_value_o   = val_q;
  assign error_estimate_o = est_q;
  assign overflow_o       = ovf_q;
  assign domain_error_o   = derr_q;

  `ASSERT_P(a_t_after_div, ctrl_i.op == OP_SETT |-> $past(ctrl_i.op) == OP_DIVSTEP)

endmodule

@@ src/chebyshev_series_evaluator.sv @@
// Chebyshev series evaluator, Clenshaw recurrence, signed Q8.24 by default.
// An item is taken when start is high and busy is low. With action_i low it
// writes coef_value_i into slot coef_index_i and gives no result;
// slots at or above MAX_ORDER are ignored. With action_i high it evaluates the
// series at x_value_i over [domain_low, domain_high] and keeps busy high.
// The config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes series_order,
// domain_low and domain_high; the user must write them only while busy is
// low, as the block does not enforce it. done_o is high for one cycle with
// the result on the output ports; the receiver cannot stall it. busy falls
// in that cycle, so the next item can be taken then.
// An evaluate item maps x onto the domain on a restoring divider, one
// quotient bit a cycle, and then runs the recurrence: for order n above 2
// each further coefficient takes 3 microcode steps on the shared multiplier
// and the single read port of the coefficient store, n-2 times in all;
// orders 1 and 2 skip that loop. A zero-width interval skips the divider
// and gives its result with domain_error_o set.
// Reset sets series_order to 1 and the interval to [-1, 1]; coefficient
// slots hold no defined value until written.
module chebyshev_series_evaluator #(
  parameter int MAX_ORDER = 16,
  parameter int FRAC_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action_i,
  input  logic [cse_pkg::COEF_IDX_W-1:0]      coef_index_i,
  input  logic signed [cse_pkg::DATA_W-1:0]   coef_value_i,
  input  logic signed [cse_pkg::DATA_W-1:0]   x_value_i,
  input  logic                                cfg_we_i,
  input  logic [cse_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cse_pkg::DATA_W-1:0]          cfg_data_i,
  output logic                                done_o,
  output logic signed [cse_pkg::DATA_W-1:0]   series_value_o,
  output logic [cse_pkg::EST_W-1:0]           error_estimate_o,
  output logic                                overflow_o,
  output logic                                domain_error_o
);
  import cse_pkg::*;

  localparam int AW = $clog2(MAX_ORDER);
  localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  cfg_t    cfg_q;
  ctrl_t   ctrl;
  stat_t   stat;
  logic    launch, coef_we;
  logic [AW-1:0] rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  assign launch  = start && !busy && (action_i == ACT_EVAL);
  assign coef_we = start && !busy && (action_i == ACT_WRITE)
                   && (32'(coef_index_i) < MAX_ORDER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.order <= ORDER_W'(1);
      cfg_q.low   <= -ONE_Q;
      cfg_q.high  <= ONE_Q;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORDER: cfg_q.order <= cfg_data_i[ORDER_W-1:0];
        CFG_LOW:   cfg_q.low   <= cfg_data_i;
        CFG_HIGH:  cfg_q.high  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cse_coef_mem #(
    .DEPTH(MAX_ORDER)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (AW'(coef_index_i)),
    .wdata_i (coef_value_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  cse_ucode_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .launch_i (launch),
    .stat_i   (stat),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  cse_datapath #(
    .MAX_ORDER(MAX_ORDER),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .launch_i         (launch),
    .x_value_i        (x_value_i),
    .ctrl_i           (ctrl),
    .cfg_i            (cfg_q),
    .rd_data_i        (rd_data),
    .rd_addr_o        (rd_addr),
    .stat_o           (stat),
    .done_o           (done_o),
    .series_value_o   (series_value_o),
    .error_estimate_o (error_estimate_o),
    .overflow_o       (overflow_o),
    .domain_error_o   (domain_error_o)
  );

  `ASSERT_P(a_done_after_busy, done_o |-> $past(busy))

endmodule
